/* rtl/core/fpd_pkg.sv */
package fpd_pkg;

  // Raw sample bytes and balancing coefficients.
  localparam int BYTE_W         = 8;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int LANES          = 4;

  // Balancing arithmetic: gain * byte, then cross * (gain * byte).
  localparam int SCALED_W  = COEF_W + BYTE_W;
  localparam int CROSS_W   = COEF_W + SCALED_W;
  localparam int OWN_W     = SCALED_W + COEF_FRAC_BITS;
  localparam int FULL_W    = ((OWN_W > CROSS_W) ? OWN_W : CROSS_W) + 2;
  localparam int BAL_FRAC  = 4;
  localparam int BAL_SHIFT = 2 * COEF_FRAC_BITS - BAL_FRAC;
  localparam int BAL_W     = 16;

  localparam logic signed [FULL_W-1:0] BAL_HALF  = FULL_W'(64'sd1 <<< (BAL_SHIFT - 1));
  localparam logic signed [FULL_W-1:0] BAL_MAX_F = FULL_W'(32767);
  localparam logic signed [FULL_W-1:0] BAL_MIN_F = FULL_W'(-32768);
  localparam logic signed [BAL_W-1:0]  BAL_MAX   = 16'sh7FFF;
  localparam logic signed [BAL_W-1:0]  BAL_MIN   = 16'sh8000;

  // Conjugate product and magnitude.
  localparam int PROD_W   = 2 * BAL_W;
  localparam int PAIR_W   = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int RAD_W    = 2 * MAG_W;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int SQ_REM_W = ROOT_W + 4;

  // Fast atan2 denominator and the quotient.
  localparam int ATAN_K_RE  = 23;
  localparam int ATAN_K_ABS = 41;
  localparam int DEN_W      = 40;
  localparam int NUM_SHIFT  = 18;
  localparam int N_W        = MAG_W + NUM_SHIFT + 2;
  localparam int D_W        = DEN_W + 1;
  localparam int Q_W        = 16;
  localparam int DCMP_W     = D_W + Q_W;
  localparam int PHASE_W    = 16;

  localparam logic [Q_W-1:0]            Q_NEG_LIMIT = 16'h8000;
  localparam logic signed [PHASE_W-1:0] PHASE_MAX   = 16'sh7FFF;
  localparam logic signed [PHASE_W-1:0] PHASE_MIN   = 16'sh8000;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_I     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_Q     = 3'd4;

  localparam logic [BYTE_W-1:0]        BYTE_OFFSET_RST = 8'd128;
  localparam logic signed [COEF_W-1:0] GAIN_RST        = 16'sd16384;

  typedef logic signed [BAL_W-1:0] bal_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        byte_offset;
    logic signed [COEF_W-1:0] gain_i;
    logic signed [COEF_W-1:0] gain_q;
    logic signed [COEF_W-1:0] cross_i;
    logic signed [COEF_W-1:0] cross_q;
  } cfg_t;

  // a + jb is the first sample, c + jd the second.
  typedef struct packed {
    bal_t a;
    bal_t b;
    bal_t c;
    bal_t d;
  } iq_pair_t;

  typedef struct packed {
    logic signed [PAIR_W-1:0] re;
    logic                     im_neg;
    logic [MAG_W-1:0]         aim;
  } side_t;

  typedef struct packed {
    logic ovf;
    logic im_neg;
    logic zero;
  } dctl_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           ovf;
    logic           im_neg;
    logic           zero;
  } div_res_t;

endpackage

/* rtl/core/fm_pair_phase_discriminator.sv */
// Throughput: one sample pair per clock; the whole pipeline holds while a result is stalled.
// The depth is set by the 32-stage square root and the 16-stage restoring divider.
// Reset is synchronous and active low: it clears every valid bit and loads the
// default configuration (offset 128, unity gains, zero cross terms).
module fm_pair_phase_discriminator
  import fpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BYTE_W-1:0]         in_i_first,
  input  logic [BYTE_W-1:0]         in_q_first,
  input  logic [BYTE_W-1:0]         in_i_second,
  input  logic [BYTE_W-1:0]         in_q_second,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PHASE_W-1:0] out_phase,
  output logic                      out_zero_denominator
);

  cfg_t                      cfg_r;
  logic                      adv;
  logic                      bal_valid, cmul_valid, sqrt_valid, div_valid;
  iq_pair_t                  pair;
  logic [RAD_W-1:0]          rad;
  side_t                     cmul_side, sqrt_side;
  logic [ROOT_W-1:0]         root;
  div_res_t                  res;
  logic signed [PHASE_W-1:0] phase_nxt;
  logic                      out_valid_r;
  logic signed [PHASE_W-1:0] out_phase_r;
  logic                      out_zero_r;

  // Every stage moves together unless a finished beat is held at the output.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.byte_offset <= BYTE_OFFSET_RST;
      cfg_r.gain_i      <= GAIN_RST;
      cfg_r.gain_q      <= GAIN_RST;
      cfg_r.cross_i     <= '0;
      cfg_r.cross_q     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BYTE_OFFSET: cfg_r.byte_offset <= cfg_data[BYTE_W-1:0];
        REG_GAIN_I:      cfg_r.gain_i      <= $signed(cfg_data);
        REG_GAIN_Q:      cfg_r.gain_q      <= $signed(cfg_data);
        REG_CROSS_I:     cfg_r.cross_i     <= $signed(cfg_data);
        REG_CROSS_Q:     cfg_r.cross_q     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  fpd_balance u_balance (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .raw       ({in_q_second, in_i_second, in_q_first, in_i_first}),
    .cfg       (cfg_r),
    .out_valid (bal_valid),
    .out_pair  (pair)
  );

  fpd_cmul u_cmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (bal_valid),
    .pair      (pair),
    .out_valid (cmul_valid),
    .rad       (rad),
    .side      (cmul_side)
  );

  fpd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cmul_valid),
    .rad       (rad),
    .in_side   (cmul_side),
    .out_valid (sqrt_valid),
    .root      (root),
    .side      (sqrt_side)
  );

  fpd_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sqrt_valid),
    .root      (root),
    .in_side   (sqrt_side),
    .out_valid (div_valid),
    .res       (res)
  );

  // Apply the sign of im and saturate; the negative side reaches one step further.
  always_comb begin
    if (res.zero) begin
      phase_nxt = '0;
    end else if (res.im_neg) begin
      if (res.ovf || (res.q > Q_NEG_LIMIT)) begin
        phase_nxt = PHASE_MIN;
      end else begin
        phase_nxt = $signed(Q_W'(~res.q + Q_W'(1)));
      end
    end else begin
      if (res.ovf || res.q[Q_W-1]) begin
        phase_nxt = PHASE_MAX;
      end else begin
        phase_nxt = $signed(res.q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase_r <= phase_nxt;
      out_zero_r  <= res.zero;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phase            = out_phase_r;
  assign out_zero_denominator = out_zero_r;

endmodule

/* rtl/core/fpd_balance.sv */
module fpd_balance
  import fpd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [LANES-1:0][BYTE_W-1:0] raw,
  input  cfg_t                        cfg,
  output logic                        out_valid,
  output iq_pair_t                    out_pair
);

  logic [2:0]                 v_r;
  logic signed [SCALED_W-1:0] scaled_nxt [LANES];
  logic signed [SCALED_W-1:0] scaled_r   [LANES];
  logic signed [SCALED_W-1:0] own_r      [LANES];
  logic signed [CROSS_W-1:0]  cprod_nxt  [LANES];
  logic signed [CROSS_W-1:0]  cprod_r    [LANES];
  logic signed [BAL_W-1:0]    bal_nxt    [LANES];
  logic signed [BAL_W-1:0]    bal_r      [LANES];

  // Lanes 0 and 2 are in-phase, 1 and 3 quadrature; a lane's partner is lane ^ 1.
  always_comb begin
    logic [BYTE_W-1:0]        adj;
    logic signed [COEF_W-1:0] gain;
    logic signed [COEF_W-1:0] xcoef;
    logic signed [FULL_W-1:0] full;
    logic signed [FULL_W-1:0] rnd;
    for (int k = 0; k < LANES; k++) begin
      adj           = BYTE_W'(raw[k] + cfg.byte_offset);
      gain          = ((k & 1) != 0) ? cfg.gain_q : cfg.gain_i;
      scaled_nxt[k] = SCALED_W'(gain) * SCALED_W'($signed(adj));

      xcoef        = ((k & 1) != 0) ? cfg.cross_q : cfg.cross_i;
      cprod_nxt[k] = CROSS_W'(xcoef) * CROSS_W'(scaled_r[k ^ 1]);

      full = (FULL_W'(own_r[k]) <<< COEF_FRAC_BITS) + FULL_W'(cprod_r[k]) + BAL_HALF;
      rnd  = full >>> BAL_SHIFT;
      if (rnd > BAL_MAX_F) begin
        bal_nxt[k] = BAL_MAX;
      end else if (rnd < BAL_MIN_F) begin
        bal_nxt[k] = BAL_MIN;
      end else begin
        bal_nxt[k] = rnd[BAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_r <= scaled_nxt;
      own_r    <= scaled_r;
      cprod_r  <= cprod_nxt;
      bal_r    <= bal_nxt;
    end
  end

  assign out_valid  = v_r[2];
  assign out_pair.a = bal_r[0];
  assign out_pair.b = bal_r[1];
  assign out_pair.c = bal_r[2];
  assign out_pair.d = bal_r[3];

endmodule

/* rtl/core/fpd_cmul.sv */
module fpd_cmul
  import fpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  iq_pair_t         pair,
  output logic             out_valid,
  output logic [RAD_W-1:0] rad,
  output side_t            side
);

  logic [4:0]               v_r;
  logic signed [PROD_W-1:0] ac_r, bd_r, bc_r, ad_r;
  logic signed [PAIR_W-1:0] re_r, im_r;
  logic signed [PAIR_W-1:0] re_abs, im_abs;
  logic [MAG_W-1:0]         are_r;
  logic [RAD_W-1:0]         sq_re_r, sq_im_r, rad_r;
  side_t                    side6_r, side7_r, side8_r;

  assign re_abs = re_r[PAIR_W-1] ? -re_r : re_r;
  assign im_abs = im_r[PAIR_W-1] ? -im_r : im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // p = s0 * conj(s1): re = ac + bd, im = bc - ad.
  always_ff @(posedge clk) begin
    if (adv) begin
      ac_r <= PROD_W'(pair.a) * PROD_W'(pair.c);
      bd_r <= PROD_W'(pair.b) * PROD_W'(pair.d);
      bc_r <= PROD_W'(pair.b) * PROD_W'(pair.c);
      ad_r <= PROD_W'(pair.a) * PROD_W'(pair.d);

      re_r <= PAIR_W'(ac_r) + PAIR_W'(bd_r);
      im_r <= PAIR_W'(bc_r) - PAIR_W'(ad_r);

      are_r          <= re_abs[MAG_W-1:0];
      side6_r.re     <= re_r;
      side6_r.im_neg <= im_r[PAIR_W-1];
      side6_r.aim    <= im_abs[MAG_W-1:0];

      sq_re_r <= RAD_W'(are_r) * RAD_W'(are_r);
      sq_im_r <= RAD_W'(side6_r.aim) * RAD_W'(side6_r.aim);
      side7_r <= side6_r;

      rad_r   <= sq_re_r + sq_im_r;
      side8_r <= side7_r;
    end
  end

  assign out_valid = v_r[4];
  assign rad       = rad_r;
  assign side      = side8_r;

endmodule

/* rtl/core/fpd_isqrt.sv */
module fpd_isqrt
  import fpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output side_t             side
);

  // One result bit per stage, two radicand bits consumed per stage.
  logic [ROOT_W-1:0]   v_r;
  logic [SQ_REM_W-1:0] rem_r    [ROOT_W];
  logic [SQ_REM_W-1:0] rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0]   root_r   [ROOT_W];
  logic [ROOT_W-1:0]   root_nxt [ROOT_W];
  logic [RAD_W-1:0]    x_r      [ROOT_W];
  logic [RAD_W-1:0]    x_nxt    [ROOT_W];
  side_t               side_r   [ROOT_W];
  side_t               side_nxt [ROOT_W];

  always_comb begin
    logic [SQ_REM_W-1:0] prem;
    logic [SQ_REM_W-1:0] cat;
    logic [SQ_REM_W-1:0] trial;
    logic [ROOT_W-1:0]   proot;
    logic [RAD_W-1:0]    px;
    logic                ge;
    for (int j = 0; j < ROOT_W; j++) begin
      if (j == 0) begin
        prem        = '0;
        proot       = '0;
        px          = rad;
        side_nxt[j] = in_side;
      end else begin
        prem        = rem_r[j-1];
        proot       = root_r[j-1];
        px          = x_r[j-1];
        side_nxt[j] = side_r[j-1];
      end
      cat         = {prem[SQ_REM_W-3:0], px[RAD_W-1 -: 2]};
      trial       = {2'b00, proot, 2'b01};
      ge          = (cat >= trial);
      rem_nxt[j]  = ge ? (cat - trial) : cat;
      root_nxt[j] = {proot[ROOT_W-2:0], ge};
      x_nxt[j]    = px << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[ROOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      x_r    <= x_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];
  assign side      = side_r[ROOT_W-1];

endmodule

/* rtl/core/fpd_divide.sv */
module fpd_divide
  import fpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] root,
  input  side_t             in_side,
  output logic              out_valid,
  output div_res_t          res
);

  localparam int STAGES = Q_W + 3;

  logic [STAGES-1:0] v_r;

  logic signed [DEN_W-1:0] den_nxt;
  logic signed [DEN_W-1:0] den_a_r;
  logic [MAG_W-1:0]        aim_a_r;
  dctl_t                   ctl_a_r;

  logic [N_W-1:0] n_b_r;
  logic [D_W-1:0] d_b_r;
  dctl_t          ctl_b_r;

  logic [N_W-1:0] n_c_r;
  logic [D_W-1:0] d_c_r;
  dctl_t          ctl_c_r;

  logic [N_W-1:0] rem_r   [Q_W];
  logic [N_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0] q_r     [Q_W];
  logic [Q_W-1:0] q_nxt   [Q_W];
  logic [D_W-1:0] dd_r    [Q_W];
  logic [D_W-1:0] dd_nxt  [Q_W];
  dctl_t          ctl_r   [Q_W];
  dctl_t          ctl_nxt [Q_W];

  // Denominator of the fast atan2: 23 * re + 41 * |p|.
  assign den_nxt = DEN_W'(ATAN_K_RE) * DEN_W'($signed(in_side.re))
                 + DEN_W'(ATAN_K_ABS) * DEN_W'(root);

  // Restoring division, one quotient bit per stage, most significant first.
  // Rounding to nearest is folded in: q = (2*num + den) / (2*den).
  always_comb begin
    logic [N_W-1:0]    prem;
    logic [Q_W-1:0]    pq;
    logic [D_W-1:0]    pd;
    logic [DCMP_W-1:0] dsh;
    logic              ge;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        prem       = n_c_r;
        pq         = '0;
        pd         = d_c_r;
        ctl_nxt[k] = ctl_c_r;
      end else begin
        prem       = rem_r[k-1];
        pq         = q_r[k-1];
        pd         = dd_r[k-1];
        ctl_nxt[k] = ctl_r[k-1];
      end
      dsh        = DCMP_W'(pd) << (Q_W - 1 - k);
      ge         = (DCMP_W'(prem) >= dsh);
      rem_nxt[k] = ge ? N_W'(DCMP_W'(prem) - dsh) : prem;
      q_nxt[k]   = pq;
      q_nxt[k][Q_W-1-k] = ge;
      dd_nxt[k]  = pd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_a_r        <= den_nxt;
      aim_a_r        <= in_side.aim;
      ctl_a_r.ovf    <= 1'b0;
      ctl_a_r.im_neg <= in_side.im_neg;
      ctl_a_r.zero   <= den_nxt[DEN_W-1] || (den_nxt == '0);

      n_b_r   <= (N_W'(aim_a_r) << (NUM_SHIFT + 1)) + N_W'(den_a_r);
      d_b_r   <= {den_a_r, 1'b0};
      ctl_b_r <= ctl_b_r_nxt(ctl_a_r);

      // A quotient that needs more than Q_W bits only ever saturates.
      n_c_r          <= n_b_r;
      d_c_r          <= d_b_r;
      ctl_c_r.ovf    <= (DCMP_W'(n_b_r) >= (DCMP_W'(d_b_r) << Q_W));
      ctl_c_r.im_neg <= ctl_b_r.im_neg;
      ctl_c_r.zero   <= ctl_b_r.zero;

      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      dd_r  <= dd_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  function automatic dctl_t ctl_b_r_nxt(input dctl_t c);
    ctl_b_r_nxt = c;
  endfunction

  assign out_valid  = v_r[STAGES-1];
  assign res.q      = q_r[Q_W-1];
  assign res.ovf    = ctl_r[Q_W-1].ovf;
  assign res.im_neg = ctl_r[Q_W-1].im_neg;
  assign res.zero   = ctl_r[Q_W-1].zero;

endmodule
